### rtl/core/kstc_pkg.sv
package kstc_pkg;

    localparam int SQ_SIDE  = 5;
    localparam int SQ_CELLS = SQ_SIDE * SQ_SIDE;
    localparam int IDX_W    = $clog2(SQ_CELLS);
    localparam int CHAR_W   = 8;

    localparam logic [CHAR_W-1:0] LETTER_FIRST = 8'd65;  // 'A'
    localparam logic [CHAR_W-1:0] LETTER_LIMIT = 8'd90;  // 'Z', first letter outside the square
    localparam logic [CHAR_W-1:0] LOWER_FIRST  = 8'd97;  // 'a'
    localparam logic [CHAR_W-1:0] LOWER_LAST   = 8'd122; // 'z'
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

    typedef enum logic [1:0] {
        ACT_KEY     = 2'd0,
        ACT_KEY_END = 2'd1,
        ACT_DECRYPT = 2'd2,
        ACT_ENCRYPT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_SQUARE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        action_t           action;
        logic [CHAR_W-1:0] char_in;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              key_ready;
    } rsp_t;

    // One letter offered to the placement unit.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } place_t;

    // Read requests into the two key tables.
    typedef struct packed {
        logic             pos_en;
        logic [IDX_W-1:0] pos_addr;
        logic             sq_en;
        logic [IDX_W-1:0] sq_addr;
    } lookup_t;

    function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
        return (c >= LOWER_FIRST && c <= LOWER_LAST) ? c - CASE_OFFSET : c;
    endfunction

    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
        return (c >= LETTER_FIRST && c <= LETTER_LIMIT) ? c + CASE_OFFSET : c;
    endfunction

    // Swap row and column of a square position (row*5+col -> col*5+row).
    function automatic logic [IDX_W-1:0] transpose_pos(input logic [IDX_W-1:0] pos);
        logic [2:0]       r;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] c;
        if (pos >= IDX_W'(4 * SQ_SIDE)) begin
            r = 3'd4;
        end else if (pos >= IDX_W'(3 * SQ_SIDE)) begin
            r = 3'd3;
        end else if (pos >= IDX_W'(2 * SQ_SIDE)) begin
            r = 3'd2;
        end else if (pos >= IDX_W'(SQ_SIDE)) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        base = {r, 2'b00} + {2'b00, r};
        c    = pos - base;
        return {c[2:0], 2'b00} + {2'b00, c[2:0]} + {2'b00, r};
    endfunction

endpackage

### rtl/core/kstc_square.sv
module kstc_square (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kstc_pkg::place_t         place,
    input  kstc_pkg::lookup_t        lookup,
    output logic [kstc_pkg::IDX_W-1:0] pos_data,
    output logic [kstc_pkg::IDX_W-1:0] sq_data,
    output logic                     complete
);
    import kstc_pkg::*;

    logic [IDX_W-1:0]    key_square [SQ_CELLS];
    logic [IDX_W-1:0]    letter_pos [SQ_CELLS];
    logic [SQ_CELLS-1:0] used_reg, used_next;
    logic [IDX_W-1:0]    fill_reg, fill_next;
    logic                complete_reg, complete_next;
    logic [IDX_W-1:0]    pos_data_reg;
    logic [IDX_W-1:0]    sq_data_reg;
    logic                do_place;

    // Place a letter only if it is new and the square still has room.
    assign do_place = place.en && !used_reg[place.idx] && !complete_reg;

    always_comb
    begin
        used_next     = used_reg;
        fill_next     = fill_reg;
        complete_next = complete_reg;
        if (do_place)
        begin
            used_next[place.idx] = 1'b1;
            fill_next            = fill_reg + 1'b1;
            complete_next        = (fill_reg == IDX_W'(SQ_CELLS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            fill_reg     <= '0;
            complete_reg <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            fill_reg     <= fill_next;
            complete_reg <= complete_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_place)
        begin
            key_square[fill_reg]  <= place.idx;
            letter_pos[place.idx] <= fill_reg;
        end
        if (lookup.pos_en)
        begin
            pos_data_reg <= letter_pos[lookup.pos_addr];
        end
        if (lookup.sq_en)
        begin
            sq_data_reg <= key_square[lookup.sq_addr];
        end
    end

    assign pos_data = pos_data_reg;
    assign sq_data  = sq_data_reg;
    assign complete = complete_reg;

endmodule

### rtl/core/keyword_square_transpose_cipher.sv
// Keyword transposing square cipher over a 5x5 square of the letters A..Y.
// A keyword request places its letter (repeats and non A..Y bytes dropped)
// and gives no response. A key-end request on an incomplete square walks all
// 25 letters through the placement unit, one per cycle, with req_stall high
// meanwhile; after that the square is complete and further key requests are
// dropped. A text request (decrypt or encrypt) on a letter A..Y with the
// square complete goes through a registered read of the letter's square
// position, a registered read of the square at the transposed position, and
// a load of the response register. Non-letters, 'Z' and any text before the
// square is complete skip both reads and go straight to the response register;
// they pass through upper-cased, and are lower-cased for decrypt. key_ready
// reports whether the square was complete. One request is in flight at a
// time; a finished response waits in its register while the next request is
// taken, and while that response is stalled the next text response is held
// back and req_stall stays high.
module keyword_square_transpose_cipher (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  kstc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output kstc_pkg::rsp_t rsp
);
    import kstc_pkg::*;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    walk_reg, walk_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic                dec_reg, dec_next;
    logic                subst_reg, subst_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    place_t              place;
    lookup_t             lookup;
    logic [IDX_W-1:0]    pos_data;
    logic [IDX_W-1:0]    sq_data;
    logic                complete;

    logic                accept;
    logic [CHAR_W-1:0]   up_char;
    logic [CHAR_W-1:0]   raw_off;
    logic [CHAR_W-1:0]   up_off;
    logic                raw_letter;
    logic                up_letter;
    logic [CHAR_W-1:0]   out_char;

    kstc_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .place    (place),
        .lookup   (lookup),
        .pos_data (pos_data),
        .sq_data  (sq_data),
        .complete (complete)
    );

    assign up_char    = to_upper(req.char_in);
    assign raw_off    = req.char_in - LETTER_FIRST;
    assign up_off     = up_char - LETTER_FIRST;
    assign raw_letter = (req.char_in >= LETTER_FIRST) && (req.char_in < LETTER_LIMIT);
    assign up_letter  = (up_char >= LETTER_FIRST) && (up_char < LETTER_LIMIT);
    assign req_stall  = (state_reg != ST_IDLE);
    assign accept     = req_valid && !req_stall;

    always_comb
    begin
        out_char = subst_reg ? (LETTER_FIRST + {3'b000, sq_data}) : ch_reg;
        if (dec_reg)
        begin
            out_char = to_lower(out_char);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        walk_next       = walk_reg;
        ch_next         = ch_reg;
        dec_next        = dec_reg;
        subst_next      = subst_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        place           = '0;
        lookup          = '0;
        lookup.pos_addr = up_off[IDX_W-1:0];
        lookup.sq_addr  = transpose_pos(pos_data);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.action)
                        ACT_KEY:
                        begin
                            place.en  = raw_letter;
                            place.idx = raw_off[IDX_W-1:0];
                        end
                        ACT_KEY_END:
                        begin
                            walk_next = '0;
                            if (!complete)
                            begin
                                state_next = ST_FILL;
                            end
                        end
                        ACT_DECRYPT, ACT_ENCRYPT:
                        begin
                            ch_next       = up_char;
                            dec_next      = (req.action == ACT_DECRYPT);
                            subst_next    = complete && up_letter;
                            lookup.pos_en = complete && up_letter;
                            state_next    = (complete && up_letter) ? ST_SQUARE : ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                place.en  = 1'b1;
                place.idx = walk_reg;
                walk_next = walk_reg + 1'b1;
                if (walk_reg == IDX_W'(SQ_CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQUARE:
            begin
                lookup.sq_en = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold until the response register is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.char_out  = out_char;
                    rsp_next.key_ready = complete;
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            walk_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            walk_reg      <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        dec_reg   <= dec_next;
        subst_reg <= subst_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### bench/keyword_square_transpose_cipher_tb.sv
module keyword_square_transpose_cipher_tb;
    import kstc_pkg::*;

    localparam int TEXT_ITEMS = 1600;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    req_t pending_reqs[$];
    rsp_t expected_chars[$];

    // Shadow copy of the key square.
    logic [4:0]  square_letter [SQ_CELLS];
    logic [4:0]  letter_slot   [SQ_CELLS];
    logic [24:0] letters_taken = '0;
    int          slots_filled  = 0;
    logic        square_done   = 1'b0;

    int   accepted_reqs = 0;
    int   errors        = 0;
    logic hold_off      = 1'b0;
    logic calm;

    keyword_square_transpose_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    // No idling on either side while this window of requests goes through.
    assign calm = (accepted_reqs >= 700) && (accepted_reqs < 1000);

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
    endfunction

    function automatic logic [7:0] downcase(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    task automatic place_letter(input int idx);
        if (idx < SQ_CELLS && slots_filled < SQ_CELLS && !letters_taken[idx]) begin
            letters_taken[idx]          = 1'b1;
            square_letter[slots_filled] = 5'(idx);
            letter_slot[idx]            = 5'(slots_filled);
            slots_filled++;
            if (slots_filled >= SQ_CELLS) square_done = 1'b1;
        end
    endtask

    task automatic cipher_predict(input req_t r);
        logic [7:0] ch;
        int         slot;
        int         tslot;
        rsp_t       want;
        case (r.action)
            ACT_KEY: begin
                if (!square_done && r.char_in >= 8'd65 && r.char_in < 8'd90)
                    place_letter(int'(r.char_in) - 65);
            end
            ACT_KEY_END: begin
                if (!square_done)
                    for (int i = 0; i < SQ_CELLS; i++) place_letter(i);
            end
            default: begin
                ch = upcase(r.char_in);
                if (square_done && ch >= 8'd65 && ch < 8'd90) begin
                    slot  = int'(letter_slot[5'(ch - 8'd65)]);
                    tslot = (slot % SQ_SIDE) * SQ_SIDE + slot / SQ_SIDE;
                    ch    = 8'd65 + 8'(square_letter[tslot]);
                end
                if (r.action == ACT_DECRYPT) ch = downcase(ch);
                want.char_out  = ch;
                want.key_ready = square_done;
                expected_chars.push_back(want);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic queue_req(input action_t a, input logic [7:0] c);
        req_t r;
        r.action  = a;
        r.char_in = c;
        pending_reqs.push_back(r);
    endtask

    // Driver: hold the payload while stalled, otherwise advance or idle.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            req       <= '0;
        end else begin
            if (req_valid && !req_stall) begin
                cipher_predict(req);
                accepted_reqs <= accepted_reqs + 1;
            end
            if (!req_valid || !req_stall) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each response with the oldest expectation.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected response", rsp.char_out, 8'h00);
                end else begin
                    if (rsp.char_out !== expected_chars[0].char_out)
                        report_mismatch("char_out", rsp.char_out, expected_chars[0].char_out);
                    if (rsp.key_ready !== expected_chars[0].key_ready)
                        report_mismatch("key_ready", 8'(rsp.key_ready),
                                        8'(expected_chars[0].key_ready));
                    void'(expected_chars.pop_front());
                end
            end
            rsp_stall <= hold_off || (!calm && $urandom_range(99) < 35);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin
        while (accepted_reqs < 300) @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        #(12 * 400000);
        $display("keyword_square_transpose_cipher_tb: FAIL");
        $finish;
    end

    initial begin
        int     texts;
        action_t a;
        logic [7:0] c;

        // Text before the square exists: case conversion only.
        queue_req(ACT_DECRYPT, "a");
        queue_req(ACT_ENCRYPT, "q");
        queue_req(ACT_ENCRYPT, 8'hFF);
        queue_req(ACT_DECRYPT, "Z");
        // Keyword bytes that must be dropped, a repeat, and the square corners.
        queue_req(ACT_KEY, "k");
        queue_req(ACT_KEY, "Z");
        queue_req(ACT_KEY, 8'h00);
        queue_req(ACT_KEY, "Y");
        queue_req(ACT_KEY, "Y");
        queue_req(ACT_KEY, "A");
        repeat (6) queue_req(ACT_KEY, 8'(65 + $urandom_range(24)));
        queue_req(ACT_KEY_END, 8'hFF);
        // Key requests once the square is complete are dropped.
        queue_req(ACT_KEY, "B");
        queue_req(ACT_KEY_END, 8'h00);
        queue_req(ACT_ENCRYPT, "A");
        queue_req(ACT_DECRYPT, "y");
        queue_req(ACT_ENCRYPT, "Z");
        queue_req(ACT_DECRYPT, "@");
        queue_req(ACT_ENCRYPT, 8'h80);
        queue_req(ACT_ENCRYPT, "z");

        texts = 0;
        while (texts < TEXT_ITEMS) begin
            if ($urandom_range(19) == 0) begin
                a = $urandom_range(1) ? ACT_KEY_END : ACT_KEY;
                queue_req(a, 8'($urandom_range(255)));
            end else begin
                a = $urandom_range(1) ? ACT_ENCRYPT : ACT_DECRYPT;
                case ($urandom_range(3))
                    0, 1:    c = 8'(65 + $urandom_range(25));
                    2:       c = 8'(97 + $urandom_range(25));
                    default: c = 8'($urandom_range(255));
                endcase
                queue_req(a, c);
                texts++;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || req_valid || expected_chars.size() > 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (expected_chars.size() > 0)
            report_mismatch("missing response", 8'h00, expected_chars[0].char_out);
        if (errors == 0)
            $display("keyword_square_transpose_cipher_tb: PASS");
        else
            $display("keyword_square_transpose_cipher_tb: FAIL");
        $finish;
    end

endmodule
